@@ rtl/tilt_pkg.sv @@
`default_nettype none
// ============================================================================
// tilt_pkg: shared types and constants for the tilt angle unit
// Item structs, datapath widths and the CORDIC arctangent table (degrees, Q16).
// ============================================================================
package tilt_pkg;

    localparam int IN_W     = 16;   // raw axis sample width
    localparam int OUT_W    = 16;   // angle output width
    localparam int ATAN_LEN = 24;   // entries in the arctangent table
    localparam int XW       = 36;   // CORDIC x/y datapath width (signed)
    localparam int ZW       = 25;   // angle accumulator width, degrees Q16
    localparam int MW       = 34;   // magnitude width, Q16 unsigned
    localparam int ANG_FRAC = 16;   // fraction bits of the accumulator
    localparam int GAIN_W   = 30;   // width of 1/K
    localparam int LO_W     = 17;   // low slice of the gain multiply
    localparam int PROD_W   = LO_W + GAIN_W;
    localparam int GAIN_SHIFT = 30;

    // 1/K of the CORDIC, Q30
    localparam logic [GAIN_W-1:0] INV_GAIN = 30'h26DD3B6A;

    typedef struct packed {
        logic signed [IN_W-1:0] accel_x;
        logic signed [IN_W-1:0] accel_y;
        logic signed [IN_W-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] pitch_deg;
        logic signed [OUT_W-1:0] roll_deg;
    } t_out_item;

    // Magnitude result handed to the angle CORDIC, with its numerator axis
    typedef struct packed {
        logic signed [IN_W-1:0] num;
        logic [MW-1:0]          mag;
    } t_mag_item;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = ZW'(2949120);
            5'd1:    v = ZW'(1740967);
            5'd2:    v = ZW'(919879);
            5'd3:    v = ZW'(466945);
            5'd4:    v = ZW'(234379);
            5'd5:    v = ZW'(117304);
            5'd6:    v = ZW'(58666);
            5'd7:    v = ZW'(29335);
            5'd8:    v = ZW'(14668);
            5'd9:    v = ZW'(7334);
            5'd10:   v = ZW'(3667);
            5'd11:   v = ZW'(1833);
            5'd12:   v = ZW'(917);
            5'd13:   v = ZW'(458);
            5'd14:   v = ZW'(229);
            5'd15:   v = ZW'(115);
            5'd16:   v = ZW'(57);
            5'd17:   v = ZW'(29);
            5'd18:   v = ZW'(14);
            5'd19:   v = ZW'(7);
            5'd20:   v = ZW'(4);
            5'd21:   v = ZW'(2);
            5'd22:   v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/accel_tilt_angles_unit.sv @@
`default_nettype none
// ============================================================================
// accel_tilt_angles_unit: pitch and roll from one accelerometer sample
// Fully pipelined CORDIC: magnitude, then arctangent, for both angles at once.
// ============================================================================
//
//  channel  dir  handshake           payload
//  -------  ---  ------------------  -------------------------------------------
//  sample   in   i_valid / o_stall   i_item: accel_x, accel_y, accel_z (s16)
//  angles   out  o_valid / i_stall   o_item: pitch_deg, roll_deg (s16, Q.FRAC)
//
//  One item per cycle sustained while the skid entry is free. The path runs through
//  the magnitude CORDIC and 1/K multiply, then the angle CORDIC and rounding, then
//  the output register; each CORDIC has N = min(CORDIC_STAGES, 24) stages.
//  Reset (i_rst_n low, synchronous) empties the pipeline; it clears the valid flags only.
//  o_stall is a register: it rises only once an item sits in the skid entry
//  behind a stalled output, so the input goes on taking items after i_stall
//  rises until a result lands in the skid entry.
//
module accel_tilt_angles_unit #(
    parameter int FRAC_BITS     = 8,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire tilt_pkg::t_in_item  i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output tilt_pkg::t_out_item      o_item
);

    logic                   ce;
    logic                   in_take;

    // magnitude results, one per angle
    logic                   pm_valid;
    logic                   rm_valid;
    tilt_pkg::t_mag_item    pm_item;
    tilt_pkg::t_mag_item    rm_item;

    // angle results
    logic                   pa_valid;
    logic                   ra_valid;
    logic signed [tilt_pkg::OUT_W-1:0] pa_angle;
    logic signed [tilt_pkg::OUT_W-1:0] ra_angle;
    tilt_pkg::t_out_item    core_item;

    // whole pipeline moves together; it holds only while the skid entry is full
    assign o_stall = !ce;
    assign in_take = i_valid && ce;

    // pitch = atan2(x, |(y, z)|)
    tilt_mag #(
        .STAGES (CORDIC_STAGES)
    ) u_mag_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (in_take),
        .i_a     (i_item.accel_y),
        .i_b     (i_item.accel_z),
        .i_num   (i_item.accel_x),
        .o_valid (pm_valid),
        .o_item  (pm_item)
    );

    // roll = atan2(y, |(x, z)|)
    tilt_mag #(
        .STAGES (CORDIC_STAGES)
    ) u_mag_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (in_take),
        .i_a     (i_item.accel_x),
        .i_b     (i_item.accel_z),
        .i_num   (i_item.accel_y),
        .o_valid (rm_valid),
        .o_item  (rm_item)
    );

    tilt_ang #(
        .STAGES    (CORDIC_STAGES),
        .FRAC_BITS (FRAC_BITS)
    ) u_ang_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (pm_valid),
        .i_item  (pm_item),
        .o_valid (pa_valid),
        .o_angle (pa_angle)
    );

    tilt_ang #(
        .STAGES    (CORDIC_STAGES),
        .FRAC_BITS (FRAC_BITS)
    ) u_ang_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (rm_valid),
        .i_item  (rm_item),
        .o_valid (ra_valid),
        .o_angle (ra_angle)
    );

    assign core_item.pitch_deg = pa_angle;
    assign core_item.roll_deg  = ra_angle;

    // both lanes carry the same valid pattern
    tilt_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pa_valid && ra_valid),
        .i_item  (core_item),
        .o_ce    (ce),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule
`default_nettype wire

@@ rtl/tilt_mag.sv @@
`default_nettype none
// ============================================================================
// tilt_mag: pipelined CORDIC magnitude sqrt(a^2 + b^2)
// Vectoring stages on |a|, |b| in Q16, then a two-stage multiply by 1/K.
// ============================================================================
module tilt_mag #(
    parameter int STAGES = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_ce,
    input  wire logic                          i_valid,
    input  wire logic signed [tilt_pkg::IN_W-1:0] i_a,
    input  wire logic signed [tilt_pkg::IN_W-1:0] i_b,
    input  wire logic signed [tilt_pkg::IN_W-1:0] i_num,
    output logic                               o_valid,
    output tilt_pkg::t_mag_item                o_item
);

    localparam int N      = (STAGES < tilt_pkg::ATAN_LEN) ? STAGES : tilt_pkg::ATAN_LEN;
    localparam int XW     = tilt_pkg::XW;
    localparam int IN_W   = tilt_pkg::IN_W;
    localparam int LO_W   = tilt_pkg::LO_W;
    localparam int PROD_W = tilt_pkg::PROD_W;
    localparam int MW     = tilt_pkg::MW;
    localparam int SUM_W  = PROD_W + LO_W;
    localparam int LAST   = N + 2;   // index of the final register stage

    // register stages: 0 = load, 1..N = CORDIC, N+1 = partial products, N+2 = sum
    logic [LAST:0]                r_v;
    logic signed [IN_W-1:0]       r_num [LAST+1];
    logic signed [XW-1:0]         r_px  [N+1];
    logic signed [XW-1:0]         r_py  [N+1];
    logic [PROD_W-1:0]            r_lo;
    logic [PROD_W-1:0]            r_hi;
    logic [MW-1:0]                r_mag;

    logic [IN_W:0]                abs_a;
    logic [IN_W:0]                abs_b;
    logic [SUM_W-1:0]             prod_sum;

    // |v| in 17 bits so that -32768 is exact
    assign abs_a = i_a[IN_W-1] ? (17'(0) - {i_a[IN_W-1], i_a}) : {1'b0, i_a};
    assign abs_b = i_b[IN_W-1] ? (17'(0) - {i_b[IN_W-1], i_b}) : {1'b0, i_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_px[0]  <= XW'({abs_a, 16'd0});
            r_py[0]  <= XW'({abs_b, 16'd0});
            r_num[0] <= i_num;
        end
    end

    for (genvar i = 0; i < LAST; i++) begin : g_num
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_num[i+1] <= r_num[i];
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        assign dx = r_py[i] >>> i;
        assign dy = r_px[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (!r_py[i][XW-1]) begin
                    r_px[i+1] <= r_px[i] + dx;
                    r_py[i+1] <= r_py[i] - dy;
                end else begin
                    r_px[i+1] <= r_px[i] - dx;
                    r_py[i+1] <= r_py[i] + dy;
                end
            end
        end
    end

    // x stays non-negative, below 2^34; split into two 17-bit slices
    assign prod_sum = {r_hi, {LO_W{1'b0}}} + SUM_W'(r_lo);

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_lo  <= r_px[N][LO_W-1:0] * tilt_pkg::INV_GAIN;
            r_hi  <= r_px[N][2*LO_W-1:LO_W] * tilt_pkg::INV_GAIN;
            r_mag <= prod_sum[tilt_pkg::GAIN_SHIFT +: MW];
        end
    end

    assign o_valid    = r_v[LAST];
    assign o_item.num = r_num[LAST];
    assign o_item.mag = r_mag;

endmodule
`default_nettype wire

@@ rtl/tilt_ang.sv @@
`default_nettype none
// ============================================================================
// tilt_ang: pipelined CORDIC arctangent in degrees
// Vectoring on (magnitude, num), rounding to FRAC_BITS and clamping to +-90.
// ============================================================================
module tilt_ang #(
    parameter int STAGES    = 16,
    parameter int FRAC_BITS = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_ce,
    input  wire logic                           i_valid,
    input  wire tilt_pkg::t_mag_item            i_item,
    output logic                                o_valid,
    output logic signed [tilt_pkg::OUT_W-1:0]   o_angle
);

    localparam int N     = (STAGES < tilt_pkg::ATAN_LEN) ? STAGES : tilt_pkg::ATAN_LEN;
    localparam int XW    = tilt_pkg::XW;
    localparam int ZW    = tilt_pkg::ZW;
    localparam int IN_W  = tilt_pkg::IN_W;
    localparam int OUT_W = tilt_pkg::OUT_W;
    localparam int SHIFT = (FRAC_BITS < tilt_pkg::ANG_FRAC) ? (tilt_pkg::ANG_FRAC - FRAC_BITS) : 0;
    localparam int HALF_I = (SHIFT > 0) ? (1 << (SHIFT - 1)) : 0;
    localparam int LIM    = (90 * 65536) >> SHIFT;
    localparam int LIM_HI_I = (LIM > 32767) ? 32767 : LIM;
    localparam int LIM_LO_I = (-LIM < -32768) ? -32768 : -LIM;
    localparam logic signed [ZW-1:0] HALF   = ZW'(HALF_I);
    localparam logic signed [ZW-1:0] LIM_HI = ZW'(LIM_HI_I);
    localparam logic signed [ZW-1:0] LIM_LO = ZW'(LIM_LO_I);
    localparam logic signed [OUT_W-1:0] OUT_HI = OUT_W'(LIM_HI_I);
    localparam logic signed [OUT_W-1:0] OUT_LO = OUT_W'(LIM_LO_I);
    localparam int LAST = N + 1;

    // stages: 0 = load, 1..N = CORDIC, N+1 = round and clamp
    logic [LAST:0]              r_v;
    logic [N:0]                 r_zero;
    logic signed [XW-1:0]       r_px [N+1];
    logic signed [XW-1:0]       r_py [N+1];
    logic signed [ZW-1:0]       r_z  [N+1];
    logic signed [OUT_W-1:0]    r_ang;

    logic signed [ZW-1:0]       z_rnd;
    logic signed [ZW-1:0]       z_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[LAST-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_px[0]   <= XW'({2'b00, i_item.mag});
            r_py[0]   <= XW'({{(XW-IN_W-16){i_item.num[IN_W-1]}}, i_item.num, 16'd0});
            r_z[0]    <= '0;
            r_zero[0] <= (i_item.num == '0);
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] da;
        assign dx = r_py[i] >>> i;
        assign dy = r_px[i] >>> i;
        assign da = tilt_pkg::atan_deg(5'(i));
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_zero[i+1] <= r_zero[i];
                if (!r_py[i][XW-1]) begin
                    r_px[i+1] <= r_px[i] + dx;
                    r_py[i+1] <= r_py[i] - dy;
                    r_z[i+1]  <= r_z[i] + da;
                end else begin
                    r_px[i+1] <= r_px[i] - dx;
                    r_py[i+1] <= r_py[i] + dy;
                    r_z[i+1]  <= r_z[i] - da;
                end
            end
        end
    end

    // round to nearest, ties up; then clamp to +-90 and to the output range
    assign z_rnd = (r_z[N] + HALF) >>> SHIFT;

    always_comb begin
        priority if (z_rnd > LIM_HI) begin
            z_sat = LIM_HI;
        end else if (z_rnd < LIM_LO) begin
            z_sat = LIM_LO;
        end else begin
            z_sat = z_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ang <= r_zero[N] ? '0 : z_sat[OUT_W-1:0];
        end
    end

    assign o_valid = r_v[LAST];
    assign o_angle = r_ang;

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle <= OUT_HI) && (o_angle >= OUT_LO))
        else $error("angle outside the clamp range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ce |=> $stable(o_valid) && $stable(o_angle))
        else $error("angle pipeline moved while held");

endmodule
`default_nettype wire

@@ rtl/tilt_skid.sv @@
`default_nettype none
// ============================================================================
// tilt_skid: output register with one skid entry
// Keeps the pipeline moving while a result waits; upstream hold is registered.
// ============================================================================
module tilt_skid (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire tilt_pkg::t_out_item i_item,
    output logic                     o_ce,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output tilt_pkg::t_out_item      o_item
);

    logic                r_o_v;
    logic                r_s_v;
    tilt_pkg::t_out_item r_o;
    tilt_pkg::t_out_item r_s;

    // pipeline advances only while the skid entry is free
    assign o_ce = !r_s_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_s_v <= 1'b0;
        end else if (r_s_v) begin
            if (!i_stall) begin
                r_s_v <= 1'b0;
            end
        end else if (!r_o_v || !i_stall) begin
            r_o_v <= i_valid;
        end else if (i_valid) begin
            r_s_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_v) begin
            if (!i_stall) begin
                r_o <= r_s;
            end
        end else if (!r_o_v || !i_stall) begin
            r_o <= i_item;
        end else begin
            r_s <= i_item;
        end
    end

    assign o_valid = r_o_v;
    assign o_item  = r_o;

    a_skid_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v |-> r_o_v)
        else $error("skid entry held with empty output register");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_v && !i_stall |=> r_o_v && !r_s_v)
        else $error("skid entry not moved to output");

endmodule
`default_nettype wire
